FILE: hdl/stream_find_replace_defines.svh
// Assertion macros for the stream find-and-replace block.
`ifndef STREAM_FIND_REPLACE_DEFINES_SVH
`define STREAM_FIND_REPLACE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that an antecedent implies a consequent in the same cycle.
`define SFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfr: implication check failed");

// Check that a condition implies a consequent in the next cycle.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfr: next-cycle check failed");

`else

`define SFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
`default_nettype none

package sfr_pkg;

    // Longest search or replacement word in bytes
    localparam int MAX_WORD = 16;
    // Width of a byte count that can hold MAX_WORD itself
    localparam int CNT_W = $clog2(MAX_WORD + 1);
    // Width of an index into a word
    localparam int IDX_W = $clog2(MAX_WORD);
    // Width of the register index on the configuration port
    localparam int REG_IDX_W = 3;
    // Width of the configuration write data
    localparam int CFG_W = 64;

    // Configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_SEARCH_LEN  = 3'd0,
        REG_SEARCH_LOW  = 3'd1,
        REG_SEARCH_HIGH = 3'd2,
        REG_REPL_LEN    = 3'd3,
        REG_REPL_LOW    = 3'd4,
        REG_REPL_HIGH   = 3'd5
    } reg_idx_t;

    // Search word as seen by the front end (length already clamped to 1..MAX_WORD)
    typedef struct packed {
        logic [CNT_W-1:0]             len;
        logic [MAX_WORD-1:0][7:0]     word;
    } search_cfg_t;

    // Replacement word as seen by the back end (length clamped to 0..MAX_WORD)
    typedef struct packed {
        logic [CNT_W-1:0]             len;
        logic [MAX_WORD-1:0][7:0]     word;
    } repl_cfg_t;

    // Command from front end to back end, one per accepted item
    typedef struct packed {
        logic                         match;        // emit the replacement word
        logic                         lead;         // emit lead_byte
        logic [7:0]                   lead_byte;
        logic [IDX_W-1:0]             flush_cnt;    // pending bytes to flush
        logic [MAX_WORD-2:0][7:0]     flush_bytes;
        logic                         last;         // item ends the string
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [7:0]                   data;
        logic                         valid;
        logic                         run_last;
        logic                         out_end;
    } res_t;

endpackage

`default_nettype wire

FILE: hdl/sfr_front.sv
// Front end: holds the pending window, matches it and issues commands.
`default_nettype none

module sfr_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 clear,
    input  wire logic                 accept,
    input  wire logic [7:0]           text_byte,
    input  wire logic                 string_end,
    input  wire sfr_pkg::search_cfg_t search,
    output sfr_pkg::cmd_t             cmd
);

    logic [sfr_pkg::CNT_W-1:0]              cnt_reg;
    logic [sfr_pkg::CNT_W-1:0]              cnt_next;
    logic [sfr_pkg::MAX_WORD-1:0][7:0]      win_reg;
    logic [sfr_pkg::MAX_WORD-1:0][7:0]      win_next;

    logic [sfr_pkg::CNT_W-1:0]              base;
    logic [sfr_pkg::CNT_W-1:0]              app_cnt;
    logic [sfr_pkg::CNT_W-1:0]              post_cnt;
    logic [sfr_pkg::MAX_WORD-1:0][7:0]      win_app;
    logic [sfr_pkg::MAX_WORD-1:0][7:0]      win_sh;
    logic [sfr_pkg::MAX_WORD-1:0][7:0]      post_win;
    logic                                   full_win;
    logic                                   hit;

    // Append the byte, compare a full window and work out what is left pending
    always_comb
    begin
        base = (cnt_reg >= search.len) ? '0 : cnt_reg;
        win_app = win_reg;
        win_app[base[sfr_pkg::IDX_W-1:0]] = text_byte;
        app_cnt = base + sfr_pkg::CNT_W'(1);
        full_win = (app_cnt == search.len);

        hit = 1'b1;
        for (int i = 0; i < sfr_pkg::MAX_WORD; i++)
        begin
            if ((sfr_pkg::CNT_W'(i) < search.len) && (win_app[i] != search.word[i]))
            begin
                hit = 1'b0;
            end
        end

        for (int i = 0; i < sfr_pkg::MAX_WORD - 1; i++)
        begin
            win_sh[i] = win_app[i + 1];
        end
        win_sh[sfr_pkg::MAX_WORD-1] = win_app[sfr_pkg::MAX_WORD-1];

        if (full_win && hit)
        begin
            post_cnt = '0;
            post_win = win_app;
        end
        else if (full_win)
        begin
            post_cnt = search.len - sfr_pkg::CNT_W'(1);
            post_win = win_sh;
        end
        else
        begin
            post_cnt = app_cnt;
            post_win = win_app;
        end

        cmd.match       = full_win && hit;
        cmd.lead        = full_win && !hit;
        cmd.lead_byte   = win_app[0];
        cmd.flush_cnt   = string_end ? post_cnt[sfr_pkg::IDX_W-1:0] : '0;
        cmd.flush_bytes = post_win[sfr_pkg::MAX_WORD-2:0];
        cmd.last        = string_end;

        cnt_next = cnt_reg;
        win_next = win_reg;
        if (clear)
        begin
            cnt_next = '0;
        end
        else if (accept)
        begin
            cnt_next = string_end ? '0 : post_cnt;
            win_next = post_win;
        end
    end

    // Hold the pending count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Hold the pending bytes
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

`default_nettype wire

FILE: hdl/sfr_cmd_queue.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none

module sfr_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sfr_pkg::cmd_t din,
    output logic               full,
    input  wire logic          pop,
    output sfr_pkg::cmd_t      dout,
    output logic               valid
);

    sfr_pkg::cmd_t  mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];

    // Count entries after this cycle's transfers
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sfr_back.sv
// Back end: expands commands into result bytes and queues them for the receiver.
`default_nettype none

module sfr_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sfr_pkg::cmd_t      cmd,
    input  wire logic               cmd_valid,
    output logic                    cmd_pop,
    input  wire sfr_pkg::repl_cfg_t repl,
    input  wire logic               res_pop,
    output logic                    res_empty,
    output sfr_pkg::res_t           res
);

    logic [sfr_pkg::CNT_W-1:0]  idx_reg;
    logic [sfr_pkg::CNT_W-1:0]  idx_next;
    sfr_pkg::res_t              oq_reg [2];
    logic                       owr_ptr_reg;
    logic                       ord_ptr_reg;
    logic [1:0]                 ocnt_reg;
    logic [1:0]                 ocnt_next;

    logic [sfr_pkg::CNT_W-1:0]  lead_cnt;
    logic [sfr_pkg::CNT_W-1:0]  total;
    logic [sfr_pkg::CNT_W-1:0]  fidx;
    logic                       space;
    logic                       emit;
    sfr_pkg::res_t              item;

    assign res_empty = (ocnt_reg == 2'd0);
    assign res       = oq_reg[ord_ptr_reg];

    // Pick the next result byte of the head command
    always_comb
    begin
        lead_cnt = cmd.match ? repl.len : {{(sfr_pkg::CNT_W-1){1'b0}}, cmd.lead};
        total    = lead_cnt + {1'b0, cmd.flush_cnt};
        fidx     = idx_reg - lead_cnt;
        space    = (ocnt_reg != 2'd2) || res_pop;
        emit     = 1'b0;
        cmd_pop  = 1'b0;
        idx_next = idx_reg;
        item     = '0;

        if (cmd_valid && space)
        begin
            if (total == '0)
            begin
                // Drop an empty command; an ending one leaves an end marker
                cmd_pop = 1'b1;
                if (cmd.last)
                begin
                    emit          = 1'b1;
                    item.run_last = 1'b1;
                    item.out_end  = 1'b1;
                end
            end
            else
            begin
                emit       = 1'b1;
                item.valid = 1'b1;
                if (idx_reg < lead_cnt)
                begin
                    item.data = cmd.match ? repl.word[idx_reg[sfr_pkg::IDX_W-1:0]]
                                          : cmd.lead_byte;
                end
                else
                begin
                    item.data = cmd.flush_bytes[fidx[sfr_pkg::IDX_W-1:0]];
                end
                item.run_last = (idx_reg == total - sfr_pkg::CNT_W'(1));
                item.out_end  = item.run_last && cmd.last;
                if (item.run_last)
                begin
                    cmd_pop  = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + sfr_pkg::CNT_W'(1);
                end
            end
        end

        ocnt_next = ocnt_reg;
        if (emit && !res_pop)
        begin
            ocnt_next = ocnt_reg + 2'd1;
        end
        else if (res_pop && !emit)
        begin
            ocnt_next = ocnt_reg - 2'd1;
        end
    end

    // Advance the byte index and the output queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            owr_ptr_reg <= 1'b0;
            ord_ptr_reg <= 1'b0;
            ocnt_reg    <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (emit)
            begin
                owr_ptr_reg <= !owr_ptr_reg;
            end
            if (res_pop)
            begin
                ord_ptr_reg <= !ord_ptr_reg;
            end
            ocnt_reg <= ocnt_next;
        end
    end

    // Store emitted results
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            oq_reg[owr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/stream_find_replace.sv
// Top level of the streaming find-and-replace block.
//
// Input queue side: drive text_byte and string_end with push; a byte is taken on
// a clock edge where push is high and full is low. Result queue side: while empty
// is low the oldest result sits on out_byte, byte_valid, run_last and output_end,
// and it is taken on an edge where pop is high. Configuration is a plain write
// port (cfg_we, cfg_index, cfg_data), to be used while the block is idle; a write
// of the search length drops any pending bytes.
// An item is registered in the command queue and its results in the result queue.
// The front end takes one byte per cycle while full is low; the back end sends
// one result per cycle while a result slot is free, and a two-entry command
// queue lets the front end run ahead while one item makes several results.
// full rises only while that queue is full, i.e. during a replacement or flush
// burst or while the receiver stalls and both result slots are in use.
// Reset empties both queues, clears the pending count and restores the
// register defaults (search length 1, everything else 0).
`default_nettype none

`include "stream_find_replace_defines.svh"

module stream_find_replace (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [7:0]                    text_byte,
    input  wire logic                          string_end,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [7:0]                         out_byte,
    output logic                               byte_valid,
    output logic                               run_last,
    output logic                               output_end,
    input  wire logic                          cfg_we,
    input  wire logic [sfr_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [sfr_pkg::CFG_W-1:0]     cfg_data
);

    logic [4:0]                 search_len_reg;
    logic [63:0]                search_low_reg;
    logic [63:0]                search_high_reg;
    logic [4:0]                 repl_len_reg;
    logic [63:0]                repl_low_reg;
    logic [63:0]                repl_high_reg;

    sfr_pkg::search_cfg_t       search;
    sfr_pkg::repl_cfg_t         repl;
    sfr_pkg::cmd_t              front_cmd;
    sfr_pkg::cmd_t              head_cmd;
    sfr_pkg::res_t              res;
    logic                       accept;
    logic                       clear;
    logic                       head_valid;
    logic                       head_pop;
    logic                       res_pop;

    assign accept  = push && !full;
    assign res_pop = pop && !empty;
    assign clear   = cfg_we && (cfg_index == sfr_pkg::REG_SEARCH_LEN);

    // Clamp the word lengths to their legal ranges
    always_comb
    begin
        search.word = {search_high_reg, search_low_reg};
        repl.word   = {repl_high_reg, repl_low_reg};
        if (search_len_reg == '0)
        begin
            search.len = sfr_pkg::CNT_W'(1);
        end
        else if (search_len_reg > sfr_pkg::CNT_W'(sfr_pkg::MAX_WORD))
        begin
            search.len = sfr_pkg::CNT_W'(sfr_pkg::MAX_WORD);
        end
        else
        begin
            search.len = search_len_reg;
        end
        if (repl_len_reg > sfr_pkg::CNT_W'(sfr_pkg::MAX_WORD))
        begin
            repl.len = sfr_pkg::CNT_W'(sfr_pkg::MAX_WORD);
        end
        else
        begin
            repl.len = repl_len_reg;
        end
    end

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_len_reg  <= 5'd1;
            search_low_reg  <= '0;
            search_high_reg <= '0;
            repl_len_reg    <= '0;
            repl_low_reg    <= '0;
            repl_high_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfr_pkg::REG_SEARCH_LEN:  search_len_reg  <= cfg_data[4:0];
                sfr_pkg::REG_SEARCH_LOW:  search_low_reg  <= cfg_data;
                sfr_pkg::REG_SEARCH_HIGH: search_high_reg <= cfg_data;
                sfr_pkg::REG_REPL_LEN:    repl_len_reg    <= cfg_data[4:0];
                sfr_pkg::REG_REPL_LOW:    repl_low_reg    <= cfg_data;
                sfr_pkg::REG_REPL_HIGH:   repl_high_reg   <= cfg_data;
                default:                  ;
            endcase
        end
    end

    sfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (clear),
        .accept     (accept),
        .text_byte  (text_byte),
        .string_end (string_end),
        .search     (search),
        .cmd        (front_cmd)
    );

    sfr_cmd_queue u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .din   (front_cmd),
        .full  (full),
        .pop   (head_pop),
        .dout  (head_cmd),
        .valid (head_valid)
    );

    sfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (head_valid),
        .cmd_pop   (head_pop),
        .repl      (repl),
        .res_pop   (res_pop),
        .res_empty (empty),
        .res       (res)
    );

    assign out_byte   = res.data;
    assign byte_valid = res.valid;
    assign run_last   = res.run_last;
    assign output_end = res.out_end;

    // The end of the output string always closes a run
    `SFR_ASSERT_IMPLY(a_end_closes_run, clk, rst_n, !empty && output_end, run_last)
    // An end marker only appears as the final result of a string
    `SFR_ASSERT_IMPLY(a_marker_is_end, clk, rst_n, !empty && !byte_valid, output_end && out_byte == 8'd0)
    // A command the back end finishes leaves the queue with room
    `SFR_ASSERT_NEXT(a_pop_frees_slot, clk, rst_n, head_pop && !accept, !full)

endmodule

`default_nettype wire
